// ----- hw/rtl/bts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    // size of the managed block, the field widths below are sized for it
    localparam int BLOCK_BYTES = 4096;

    // field widths of the request and response
    localparam int OP_W     = 1;
    localparam int REQ_W    = 13;
    localparam int OFS_W    = 12;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 13;

    // request operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NO_FIT   = 2'd2,
        ST_BAD_OFS  = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [REQ_W-1:0] request_bytes;
        logic [OFS_W-1:0] payload_offset;
    } t_req;

    typedef struct packed {
        logic [OFS_W-1:0]  granted_offset;
        t_status           status;
        logic [FREE_W-1:0] free_bytes;
    } t_rsp;

    // sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CMP,
        S_A_ADV,
        S_A_SPLIT,
        S_A_AFT,
        S_A_WAFT,
        S_A_OK,
        S_R_RD,
        S_R_CHK,
        S_R_ADV,
        S_R_P,
        S_R_N,
        S_R_M,
        S_R_M2,
        S_R_WB,
        S_R_WN,
        S_R_NN,
        S_R_WNN,
        S_R_OK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/boundary_tag_slot_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// First-fit slot allocator over one block of BLOCK_BYTES bytes.
// Request channel: i_in_valid / o_in_stall carry a t_req (allocate or
// release). Response channel: o_out_valid / i_out_stall carry a t_rsp with
// the granted payload offset, a status code and the free byte count.
// One request is worked at a time; o_in_stall stays high until its response
// has been loaded into the output register.
// Allocate walks the slot headers, then writes the chosen header and, on a
// split, also the remainder header and the prev field of the slot after.
// Release walks the slots before the target, reads both neighbors and
// merges with the free ones. Requests rejected before any walk go straight
// to the response. The walk is paced by the single read port of the
// header memory (one header per read, registered read data) and the one
// shared adder. After reset the block writes the first header (one free
// slot over the whole block) and then accepts requests.
// When the receiver stalls, the response holds in the output register; a
// new request is taken, but its response waits until the register frees.
module boundary_tag_slot_allocator #(
    parameter int HEADER_BYTES = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bts_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bts_pkg::t_rsp      o_out_rsp
);

    import bts_pkg::*;

    localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int LW = $clog2(BLOCK_BYTES + 1);
    localparam int W  = (LW > 14) ? LW : 14;
    localparam int DW = 1 + 2 * LW;

    localparam logic [W-1:0]  HDR_W   = W'(HEADER_BYTES);
    localparam logic [W-1:0]  BLK_W   = W'(BLOCK_BYTES);
    localparam logic [LW-1:0] BLK_L   = LW'(BLOCK_BYTES);

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out_rsp, n_out_rsp;
    logic [LW-1:0] r_free, n_free;

    logic [LW-1:0] r_pos, n_pos;
    logic [W-1:0]  r_need, n_need;
    logic [W-1:0]  r_target, n_target;
    logic          r_used, n_used;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_diff, n_diff;
    logic [LW-1:0] r_p, n_p;
    logic [LW-1:0] r_n, n_n;
    logic          r_hasp, n_hasp;
    logic          r_hasn, n_hasn;
    logic          r_pused, n_pused;
    logic [LW-1:0] r_plen, n_plen;
    logic [LW-1:0] r_pprev, n_pprev;
    logic          r_nused, n_nused;
    logic [LW-1:0] r_nlen, n_nlen;
    logic          r_mp, n_mp;
    logic          r_mn, n_mn;
    logic [LW-1:0] r_newlen, n_newlen;
    logic [OFS_W-1:0] r_gr, n_gr;
    t_status       r_st, n_st;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic          rd_used;
    logic [LW-1:0] rd_len;
    logic [LW-1:0] rd_prev;

    logic [W-1:0]  alu_a, alu_b, alu_y;
    logic          alu_sub, alu_ge;

    bts_hdr_mem #(
        .DEPTH (BLOCK_BYTES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bts_alu #(
        .W (W)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y),
        .o_ge  (alu_ge)
    );

    // header fields of the last read
    assign rd_used = mem_rdata[DW-1];
    assign rd_len  = mem_rdata[2*LW-1:LW];
    assign rd_prev = mem_rdata[LW-1:0];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_free      <= BLK_L;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free      <= n_free;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_out_rsp <= n_out_rsp;
        r_pos     <= n_pos;
        r_need    <= n_need;
        r_target  <= n_target;
        r_used    <= n_used;
        r_len     <= n_len;
        r_prev    <= n_prev;
        r_diff    <= n_diff;
        r_p       <= n_p;
        r_n       <= n_n;
        r_hasp    <= n_hasp;
        r_hasn    <= n_hasn;
        r_pused   <= n_pused;
        r_plen    <= n_plen;
        r_pprev   <= n_pprev;
        r_nused   <= n_nused;
        r_nlen    <= n_nlen;
        r_mp      <= n_mp;
        r_mn      <= n_mn;
        r_newlen  <= n_newlen;
        r_gr      <= n_gr;
        r_st      <= n_st;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rsp   = r_out_rsp;
        n_free      = r_free;
        n_pos       = r_pos;
        n_need      = r_need;
        n_target    = r_target;
        n_used      = r_used;
        n_len       = r_len;
        n_prev      = r_prev;
        n_diff      = r_diff;
        n_p         = r_p;
        n_n         = r_n;
        n_hasp      = r_hasp;
        n_hasn      = r_hasn;
        n_pused     = r_pused;
        n_plen      = r_plen;
        n_pprev     = r_pprev;
        n_nused     = r_nused;
        n_nlen      = r_nlen;
        n_mp        = r_mp;
        n_mn        = r_mn;
        n_newlen    = r_newlen;
        n_gr        = r_gr;
        n_st        = r_st;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_wdata   = '0;
        mem_raddr   = r_pos[AW-1:0];
        alu_a       = W'(r_pos);
        alu_b       = W'(r_len);
        alu_sub     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // first header: one free slot over the whole block
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {1'b0, BLK_L, {LW{1'b0}}};
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                n_pos = '0;
                n_gr  = '0;
                if (i_in_req.operation == OP_ALLOC) begin
                    alu_a  = W'(i_in_req.request_bytes);
                    alu_b  = HDR_W;
                    n_need = alu_y;
                end else begin
                    alu_a    = W'(i_in_req.payload_offset);
                    alu_b    = HDR_W;
                    alu_sub  = 1'b1;
                    n_target = alu_y;
                end
                if (i_in_valid) begin
                    if (i_in_req.operation == OP_ALLOC) begin
                        if (i_in_req.request_bytes == '0) begin
                            n_st    = ST_ZERO;
                            n_state = S_DONE;
                        end else if (r_free == '0) begin
                            n_st    = ST_NO_FIT;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else if (!alu_ge) begin
                        n_st    = ST_BAD_OFS;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_R_RD;
                    end
                end
            end
            // allocate: read the header at the walk position
            S_A_RD: begin
                if (r_pos >= BLK_L) begin
                    n_st    = ST_NO_FIT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_A_CMP;
                end
            end
            // allocate: fit check, len - need
            S_A_CMP: begin
                n_used  = rd_used;
                n_len   = rd_len;
                n_prev  = rd_prev;
                alu_a   = W'(rd_len);
                alu_b   = r_need;
                alu_sub = 1'b1;
                n_diff  = alu_y[LW-1:0];
                if (rd_len == '0) begin
                    n_st    = ST_NO_FIT;
                    n_state = S_DONE;
                end else if (!rd_used && alu_ge) begin
                    mem_we = 1'b1;
                    if (alu_y == '0) begin
                        mem_wdata = {1'b1, rd_len, rd_prev};
                        n_state   = S_A_OK;
                    end else begin
                        mem_wdata = {1'b1, r_need[LW-1:0], rd_prev};
                        n_state   = S_A_SPLIT;
                    end
                end else begin
                    n_state = S_A_ADV;
                end
            end
            S_A_ADV: begin
                n_pos   = alu_y[LW-1:0];
                n_state = S_A_RD;
            end
            // allocate: remainder header after the split
            S_A_SPLIT: begin
                alu_b     = r_need;
                mem_we    = 1'b1;
                mem_waddr = alu_y[AW-1:0];
                mem_wdata = {1'b0, r_diff, r_need[LW-1:0]};
                n_state   = S_A_AFT;
            end
            // allocate: fetch the slot after the old free slot
            S_A_AFT: begin
                n_n       = alu_y[LW-1:0];
                mem_raddr = alu_y[AW-1:0];
                if (alu_y < BLK_W) begin
                    n_state = S_A_WAFT;
                end else begin
                    n_state = S_A_OK;
                end
            end
            S_A_WAFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_n[AW-1:0];
                mem_wdata = {rd_used, rd_len, r_diff};
                n_state   = S_A_OK;
            end
            S_A_OK: begin
                alu_a   = W'(r_free);
                alu_b   = r_need;
                alu_sub = 1'b1;
                n_free  = alu_y[LW-1:0];
                n_gr    = OFS_W'(W'(r_pos) + HDR_W);
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            // release: walk the chain to the target header
            S_R_RD: begin
                if (r_pos >= BLK_L || W'(r_pos) > r_target) begin
                    n_st    = ST_BAD_OFS;
                    n_state = S_DONE;
                end else begin
                    n_state = S_R_CHK;
                end
            end
            S_R_CHK: begin
                n_used = rd_used;
                n_len  = rd_len;
                n_prev = rd_prev;
                if (W'(r_pos) == r_target) begin
                    if (!rd_used) begin
                        n_st    = ST_BAD_OFS;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_R_P;
                    end
                end else if (rd_len == '0) begin
                    n_st    = ST_BAD_OFS;
                    n_state = S_DONE;
                end else begin
                    n_state = S_R_ADV;
                end
            end
            S_R_ADV: begin
                n_pos   = alu_y[LW-1:0];
                n_state = S_R_RD;
            end
            // release: previous neighbor
            S_R_P: begin
                alu_b     = W'(r_prev);
                alu_sub   = 1'b1;
                n_p       = alu_y[LW-1:0];
                n_hasp    = (r_prev != '0);
                mem_raddr = alu_y[AW-1:0];
                n_state   = S_R_N;
            end
            // release: next neighbor
            S_R_N: begin
                n_pused   = rd_used;
                n_plen    = rd_len;
                n_pprev   = rd_prev;
                n_n       = alu_y[LW-1:0];
                n_hasn    = (alu_y < BLK_W);
                mem_raddr = alu_y[AW-1:0];
                n_state   = S_R_M;
            end
            // release: merge decision and first length sum
            S_R_M: begin
                n_nused  = rd_used;
                n_nlen   = rd_len;
                n_mp     = r_hasp && !r_pused;
                n_mn     = r_hasn && !rd_used;
                alu_a    = (r_hasp && !r_pused) ? W'(r_plen) : W'(r_len);
                alu_b    = (r_hasp && !r_pused) ? W'(r_len) : W'(rd_len);
                n_newlen = alu_y[LW-1:0];
                n_state  = S_R_M2;
            end
            S_R_M2: begin
                unique case ({r_mp, r_mn})
                    2'b00: begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, r_len, r_prev};
                        n_state   = S_R_OK;
                    end
                    2'b10: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_p[AW-1:0];
                        mem_wdata = {1'b0, r_newlen, r_pprev};
                        n_state   = r_hasn ? S_R_WN : S_R_OK;
                    end
                    2'b01: begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, r_newlen, r_prev};
                        n_state   = S_R_NN;
                    end
                    default: begin
                        alu_a    = W'(r_newlen);
                        alu_b    = W'(r_nlen);
                        n_newlen = alu_y[LW-1:0];
                        n_state  = S_R_WB;
                    end
                endcase
            end
            S_R_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_p[AW-1:0];
                mem_wdata = {1'b0, r_newlen, r_pprev};
                n_state   = S_R_NN;
            end
            S_R_WN: begin
                mem_we    = 1'b1;
                mem_waddr = r_n[AW-1:0];
                mem_wdata = {r_nused, r_nlen, r_newlen};
                n_state   = S_R_OK;
            end
            // release: slot after the merged next neighbor
            S_R_NN: begin
                alu_a     = W'(r_n);
                alu_b     = W'(r_nlen);
                n_p       = (r_mp) ? r_p : r_pos;
                n_n       = alu_y[LW-1:0];
                mem_raddr = alu_y[AW-1:0];
                n_state   = (alu_y < BLK_W) ? S_R_WNN : S_R_OK;
            end
            S_R_WNN: begin
                mem_we    = 1'b1;
                mem_waddr = r_n[AW-1:0];
                mem_wdata = {rd_used, rd_len, r_newlen};
                n_state   = S_R_OK;
            end
            S_R_OK: begin
                alu_a   = W'(r_free);
                alu_b   = W'(r_len);
                n_free  = alu_y[LW-1:0];
                n_st    = ST_OK;
                n_state = S_DONE;
            end
            // load the response once the output register is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_rsp.granted_offset = r_gr;
                    n_out_rsp.status         = r_st;
                    n_out_rsp.free_bytes     = FREE_W'(r_free);
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bts_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_alu #(
    parameter int W = 14
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output logic      [W-1:0] o_y,
    output logic              o_ge
);

    logic [W:0] sum;

    // shared add / subtract, carry out gives a >= b on subtract
    always_comb begin
        sum  = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (W+1)'(i_sub);
        o_y  = sum[W-1:0];
        o_ge = sum[W];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bts_hdr_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 27
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/bts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire bts_pkg::t_req i_in_req,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire bts_pkg::t_rsp o_out_rsp
);

    import bts_pkg::*;

    // no response is pending right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // a stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_req))
        else $error("stalled request changed");

    // one request at a time: an accepted request closes the input
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while busy");

    // only a good allocate carries an offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status != ST_OK |-> o_out_rsp.granted_offset == '0)
        else $error("offset on failed request");

endmodule

bind boundary_tag_slot_allocator bts_checker u_bts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

// ----- tb/boundary_tag_slot_allocator_test.sv -----
`timescale 1ns / 1ps

module boundary_tag_slot_allocator_test;
    import bts_pkg::*;

    localparam int BLOCK  = 4096;
    localparam int HDR    = 8;
    localparam int N_RAND = 1700;

    // slot chain predictor with its own copy of the headers
    class slot_scoreboard;
        bit        used[BLOCK];
        int        len[BLOCK];
        int        prev[BLOCK];
        int        free_cnt;
        t_rsp      pending[$];
        int        errors;
        int        live[$];

        function void clear_chain();
            int k;
            for (k = 0; k < BLOCK; k++) begin
                used[k] = 0;
                len[k] = 0;
                prev[k] = 0;
            end
            len[0] = BLOCK;
            free_cnt = BLOCK;
            errors = 0;
        endfunction

        function t_rsp allocate(int want);
            t_rsp r;
            int need, pos, l, rest, after;
            r.granted_offset = '0;
            r.status = ST_NO_FIT;
            if (want == 0) r.status = ST_ZERO;
            else if (free_cnt != 0) begin
                need = want + HDR;
                pos = 0;
                while (pos < BLOCK && len[pos] != 0) begin
                    l = len[pos];
                    if (!used[pos] && l >= need) begin
                        used[pos] = 1;
                        if (l > need) begin
                            rest = pos + need;
                            after = pos + l;
                            len[pos] = need;
                            if (rest < BLOCK) begin
                                used[rest] = 0;
                                len[rest] = l - need;
                                prev[rest] = need;
                            end
                            if (after < BLOCK) prev[after] = l - need;
                        end
                        free_cnt -= need;
                        r.granted_offset = OFS_W'(pos + HDR);
                        r.status = ST_OK;
                        live.push_back(pos + HDR);
                        break;
                    end
                    pos += l;
                end
            end
            r.free_bytes = FREE_W'(free_cnt);
            return r;
        endfunction

        function t_rsp release_slot(int ofs);
            t_rsp r;
            int t, pos, l, pl, p, n, nn, k;
            bit found, hp, hn, mp, mn;
            r.granted_offset = '0;
            r.status = ST_BAD_OFS;
            r.free_bytes = FREE_W'(free_cnt);
            if (ofs < HDR) return r;
            t = ofs - HDR;
            pos = 0;
            found = 0;
            while (pos < BLOCK && pos <= t) begin
                if (pos == t) begin
                    found = 1;
                    break;
                end
                if (len[pos] == 0) break;
                pos += len[pos];
            end
            if (!found || !used[t]) return r;
            l = len[t];
            pl = prev[t];
            hp = pl != 0 && t >= pl;
            p = hp ? t - pl : 0;
            n = t + l;
            hn = n < BLOCK;
            mp = hp && !used[p];
            mn = hn && !used[n];
            // four merge cases
            if (!mp && !mn) begin
                used[t] = 0;
            end else if (mp && !mn) begin
                len[p] += l;
                if (hn) prev[n] = len[p];
            end else if (!mp && mn) begin
                nn = n + len[n];
                used[t] = 0;
                len[t] = l + len[n];
                if (nn < BLOCK) prev[nn] = len[t];
            end else begin
                nn = n + len[n];
                len[p] = len[p] + l + len[n];
                if (nn < BLOCK) prev[nn] = len[p];
            end
            free_cnt += l;
            for (k = 0; k < live.size(); k++)
                if (live[k] == ofs) begin
                    live.delete(k);
                    break;
                end
            r.status = ST_OK;
            r.free_bytes = FREE_W'(free_cnt);
            return r;
        endfunction

        function void note_request(t_req q);
            if (q.operation == OP_ALLOC) pending.push_back(allocate(int'(q.request_bytes)));
            else pending.push_back(release_slot(int'(q.payload_offset)));
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp;
            if (pending.size() == 0) begin
                $error("response with nothing expected: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.granted_offset !== exp.granted_offset) begin
                $error("granted_offset exp %0d got %0d", exp.granted_offset,
                       got.granted_offset);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status);
                errors++;
            end
            if (got.free_bytes !== exp.free_bytes) begin
                $error("free_bytes exp %0d got %0d", exp.free_bytes, got.free_bytes);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_rsp;

    slot_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    boundary_tag_slot_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // response side: random stall and checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_rsp);
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // present one request and hold it until taken; valid is left up for the
    // next request or dropped by wait_drained
    task automatic send_request(input logic op, input int bytes, input int ofs);
        t_req q;
        q.operation = op;
        q.request_bytes = REQ_W'(bytes);
        q.payload_offset = OFS_W'(ofs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(q);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // mostly small sizes, some large, rarely zero
    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 0;
        if (r < 70) return $urandom_range(1, 64);
        if (r < 92) return $urandom_range(65, 512);
        return $urandom_range(513, 4096);
    endfunction

    task automatic random_phase(input int count);
        int k, r, pick;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                send_request(OP_ALLOC, pick_size(), $urandom_range(4095));
            end else if (r < 85 && sb.live.size() != 0) begin
                pick = $urandom_range(sb.live.size() - 1);
                send_request(OP_RELEASE, $urandom_range(8191), sb.live[pick]);
            end else begin
                send_request(OP_RELEASE, $urandom_range(8191), $urandom_range(4095));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear_chain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, rejects, merges with no neighbor, the next one and both
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_RELEASE, 0, 0);
        send_request(OP_RELEASE, 8191, 7);
        send_request(OP_ALLOC, 4096, 4095);
        send_request(OP_ALLOC, 4088, 0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_RELEASE, 0, 8);
        send_request(OP_RELEASE, 0, 8);
        send_request(OP_RELEASE, 0, 4095);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_RELEASE, 0, 8);
        send_request(OP_RELEASE, 0, 56);
        send_request(OP_RELEASE, 0, 32);
        send_request(OP_RELEASE, 0, 80);
        send_request(OP_ALLOC, 4085, 0);
        send_request(OP_RELEASE, 0, 8);
        send_request(OP_ALLOC, 4095, 0);
        send_request(OP_RELEASE, 0, 12);

        // sender pauses until all responses are in
        wait_drained();
        repeat (40) @(posedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 49;
        random_phase(N_RAND / 3);
        send_idle_pct = 49;
        recv_idle_pct = 25;
        random_phase(N_RAND / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(N_RAND / 3);
        // free everything to exercise long merges
        while (sb.live.size() != 0) send_request(OP_RELEASE, 0, sb.live[0]);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
